>>> hw/rtl/vdi_pkg.sv
// ----------------------------------------------------------------------------
// vdi_pkg: shared types and helpers for the vertex dedup indexer
// Lane count, the token that travels down the cell chain, and float compare.
// ----------------------------------------------------------------------------
`default_nettype none

package vdi_pkg;

  localparam int LANES  = 4;
  localparam int LANE_W = 2;
  localparam int KEY_W  = 96;

  localparam logic [31:0] ABS_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] EXP_MASK = 32'h7F80_0000;
  localparam logic [31:0] MAN_MASK = 32'h007F_FFFF;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              found;
    logic [LANE_W-1:0] found_lane;
  } token_t;

  function automatic logic is_nan32(input logic [31:0] v);
    return ((v & EXP_MASK) == EXP_MASK) && ((v & MAN_MASK) != 32'h0);
  endfunction

  function automatic logic feq32(input logic [31:0] a, input logic [31:0] b);
    logic eq;
    if (is_nan32(a) || is_nan32(b)) begin
      eq = 1'b0;
    end else if (((a & ABS_MASK) == 32'h0) && ((b & ABS_MASK) == 32'h0)) begin
      eq = 1'b1;
    end else begin
      eq = (a == b);
    end
    return eq;
  endfunction

  function automatic logic key_match(input logic [KEY_W-1:0] a,
                                     input logic [KEY_W-1:0] b);
    return feq32(a[31:0], b[31:0]) && feq32(a[63:32], b[63:32]) &&
           feq32(a[95:64], b[95:64]);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vdi_cell.sv
// ----------------------------------------------------------------------------
// vdi_cell: one lane of the position table
// Holds every LANES-th stored position, compares the row named by the
// passing token against the key and hands the token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module vdi_cell #(
  parameter int ROWS  = 256,
  parameter int ROW_W = 8,
  parameter int CNT_W = 11,
  parameter int LANE  = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [ROW_W-1:0]         wr_row,
  input  wire logic [vdi_pkg::KEY_W-1:0] wr_data,
  input  wire logic [vdi_pkg::KEY_W-1:0] key,
  input  wire logic [CNT_W-1:0]         count,
  input  wire vdi_pkg::token_t          tok_in,
  input  wire logic [ROW_W-1:0]         row_in,
  input  wire logic [ROW_W-1:0]         frow_in,
  output vdi_pkg::token_t               tok_out,
  output logic [ROW_W-1:0]              row_out,
  output logic [ROW_W-1:0]              frow_out
);
  import vdi_pkg::*;

  localparam int ENT_W = ROW_W + LANE_W;
  localparam int CMP_W = (ENT_W > CNT_W) ? ENT_W : CNT_W;

  logic [KEY_W-1:0] bank [ROWS];
  logic [KEY_W-1:0] rd_data_r;
  token_t           tok_r;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] frow_r;
  logic [ENT_W-1:0] ent;
  logic             ent_ok;
  logic             hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank[wr_row] <= wr_data;
    end
    rd_data_r <= bank[row_in];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
    row_r  <= row_in;
    frow_r <= frow_in;
  end

  always_comb begin
    ent      = {row_r, LANE_W'(LANE)};
    ent_ok   = CMP_W'(ent) < CMP_W'(count);
    hit      = tok_r.valid && ent_ok && key_match(rd_data_r, key);
    tok_out  = tok_r;
    row_out  = row_r;
    frow_out = frow_r;
    if (hit && !tok_r.found) begin
      tok_out.found      = 1'b1;
      tok_out.found_lane = LANE_W'(LANE);
      frow_out           = row_r;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/vertex_dedup_indexer.sv
// ----------------------------------------------------------------------------
// vertex_dedup_indexer: vertex welding by position lookup
// Returns the stored index of a known position, stores a new one, or flags a full table.
//
//   channel  direction  payload
//   in_      input      start_mesh, pos_x/y/z, norm_x/y/z
//   out_     output     vertex_index, is_new, table_full, out_x..out_nz
//
// A scan token enters the 4-cell chain once per occupied table row, counted from
// the number of stored positions after any restart; an empty table skips the
// scan.
// Reset empties the table at once (entry count cleared, no sweep).
// A stalled result holds in the output register; the next item is taken once
// the previous result has moved there, and after its scan it waits for a free
// output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_dedup_indexer #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_start_mesh,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [31:0] in_norm_x,
  input  wire logic [31:0] in_norm_y,
  input  wire logic [31:0] in_norm_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       out_vertex_index,
  output logic             out_is_new,
  output logic             out_table_full,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic [31:0]      out_z,
  output logic [31:0]      out_nx,
  output logic [31:0]      out_ny,
  output logic [31:0]      out_nz
);
  import vdi_pkg::*;

  localparam int ROWS  = (TABLE_DEPTH + LANES - 1) / LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DECIDE} state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   count_r;
  logic [ROW_W-1:0]   row_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [KEY_W-1:0]   key_r;
  logic [31:0]        nx_r, ny_r, nz_r;
  logic               out_valid_r;

  token_t             tok_chain  [LANES+1];
  logic [ROW_W-1:0]   row_chain  [LANES+1];
  logic [ROW_W-1:0]   frow_chain [LANES+1];

  logic [CNT_W-1:0]   cnt_m1;
  logic [ROW_W-1:0]   last_row;
  logic [CNT_W-1:0]   count_in;
  logic               out_free;
  logic               load;
  logic               mem_we;
  logic [ROW_W-1:0]   wr_row;
  logic [LANE_W-1:0]  wr_lane;
  logic [IDX_W+9:0]   idx_ext_r;
  token_t             tok_end;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign load      = (state_r == S_DECIDE) && out_free;
  assign mem_we    = load && !hit_r && (count_r != FULL_CNT);
  assign wr_row    = ROW_W'(count_r >> LANE_W);
  assign wr_lane   = count_r[LANE_W-1:0];
  assign cnt_m1    = count_r - CNT_W'(1);
  assign last_row  = ROW_W'(cnt_m1 >> LANE_W);
  assign count_in  = in_start_mesh ? '0 : count_r;
  assign tok_end   = tok_chain[LANES];

  always_comb begin
    tok_chain[0]            = '0;
    tok_chain[0].valid      = (state_r == S_SCAN);
    tok_chain[0].last       = (row_r == last_row);
    row_chain[0]            = row_r;
    frow_chain[0]           = '0;
  end

  for (genvar k = 0; k < LANES; k++) begin : g_cell
    vdi_cell #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W),
      .CNT_W (CNT_W),
      .LANE  (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (mem_we && (wr_lane == LANE_W'(k))),
      .wr_row   (wr_row),
      .wr_data  (key_r),
      .key      (key_r),
      .count    (count_r),
      .tok_in   (tok_chain[k]),
      .row_in   (row_chain[k]),
      .frow_in  (frow_chain[k]),
      .tok_out  (tok_chain[k+1]),
      .row_out  (row_chain[k+1]),
      .frow_out (frow_chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !load) begin
        out_valid_r <= 1'b0;
      end
      if (tok_end.valid && tok_end.found && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= IDX_W'({frow_chain[LANES], tok_end.found_lane});
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            key_r   <= {in_pos_z, in_pos_y, in_pos_x};
            nx_r    <= in_norm_x;
            ny_r    <= in_norm_y;
            nz_r    <= in_norm_z;
            count_r <= count_in;
            row_r   <= '0;
            hit_r   <= 1'b0;
            state_r <= (count_in == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          row_r <= row_r + ROW_W'(1);
          if (row_r == last_row) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (tok_end.valid && tok_end.last) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (hit_r) begin
              idx_ext_r      <= {10'b0, hit_idx_r};
              out_is_new     <= 1'b0;
              out_table_full <= 1'b0;
              out_x <= '0; out_y <= '0; out_z <= '0;
              out_nx <= '0; out_ny <= '0; out_nz <= '0;
            end else if (count_r == FULL_CNT) begin
              idx_ext_r      <= '0;
              out_is_new     <= 1'b0;
              out_table_full <= 1'b1;
              out_x <= '0; out_y <= '0; out_z <= '0;
              out_nx <= '0; out_ny <= '0; out_nz <= '0;
            end else begin
              idx_ext_r      <= {10'b0, count_r[IDX_W-1:0]};
              out_is_new     <= 1'b1;
              out_table_full <= 1'b0;
              out_x  <= key_r[31:0];
              out_y  <= key_r[63:32];
              out_z  <= key_r[95:64];
              out_nx <= nx_r;
              out_ny <= ny_r;
              out_nz <= nz_r;
              count_r <= count_r + CNT_W'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_vertex_index = idx_ext_r[9:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above table depth");

  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.valid |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("token left the chain outside a scan");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not advance the entry count");

  a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_is_new && out_table_full))
    else $error("result both new and full");

endmodule

`default_nettype wire
